FILE: rtl/core/rsp_pkg.sv
// ---------------------------------------------------------------------------
// rsp_pkg: shared definitions for the reference-counted slot pool
// Field widths, request and status codes, and the update strobes that pass
// from the request decoder to the state registers.
// ---------------------------------------------------------------------------
package rsp_pkg;

  // Item field widths.
  localparam int FUNC_W       = 3;
  localparam int HANDLE_W     = 4;
  localparam int KIND_W       = 2;
  localparam int RES_HANDLE_W = 3;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 16;

  // Default sizing.
  localparam int SLOTS_DEF       = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Request codes.
  localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RETAIN  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SEND    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RECV    = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd5;

  // State update strobes produced for one request.
  typedef struct packed {
    logic tag_we;
    logic cnt_we;
    logic push;
    logic pop;
  } upd_t;

endpackage

FILE: rtl/core/rsp_chan_if.sv
// ---------------------------------------------------------------------------
// rsp_chan_if: valid/ready channels of the slot pool
// Request channel and result channel, each with source and sink modports.
// ---------------------------------------------------------------------------
interface rsp_in_if import rsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [HANDLE_W-1:0] slot_handle;
  logic [KIND_W-1:0]   slot_kind;

  modport source (output valid, func, slot_handle, slot_kind, input ready);
  modport sink   (input valid, func, slot_handle, slot_kind, output ready);
endinterface

interface rsp_out_if import rsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [RES_HANDLE_W-1:0] result_handle;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_W-1:0]      count_after;

  modport source (output valid, result_handle, status, count_after, input ready);
  modport sink   (input valid, result_handle, status, count_after, output ready);
endinterface

FILE: rtl/core/refcounted_slot_pool_with_fifo.sv
// ---------------------------------------------------------------------------
// refcounted_slot_pool_with_fifo: reference-counted slot pool with queue
// Slot allocator with per-slot type tags and reference counts, plus one
// bounded circular queue of slot handles.
// ---------------------------------------------------------------------------
// Path: an accepted request is held in the input register and then moves
//   into the result register, which offers it; while a full result register
//   is stalled, the request waits in the input register.
// Throughput: one item per cycle while results are taken; the pool and queue
//   state is updated in the same cycle that the result register loads.
// Reset: synchronous, active low. All slots become free with zero counts and
//   the queue becomes empty; no clearing pass is needed.
// ---------------------------------------------------------------------------
module refcounted_slot_pool_with_fifo import rsp_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  rsp_in_if.sink  in_chan,
  rsp_out_if.source out_chan
);

  localparam int SW = $clog2(SLOTS);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  // Pool and queue state.
  logic [KIND_W-1:0]  tag_r   [SLOTS];
  logic [COUNT_W-1:0] cnt_r   [SLOTS];
  logic [SW-1:0]      queue_r [QUEUE_DEPTH];
  logic [PW-1:0]      rd_pos_r, rd_pos_nxt;
  logic [PW-1:0]      wr_pos_r, wr_pos_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;

  // Input register holding the request waiting to be decided.
  logic                s1_valid_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [HANDLE_W-1:0] s1_handle_r;
  logic [KIND_W-1:0]   s1_kind_r;

  // Result register.
  logic                    out_valid_r;
  logic [RES_HANDLE_W-1:0] out_handle_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [COUNT_W-1:0]      out_count_r;

  // Decoder outputs.
  upd_t                    upd;
  logic [SW-1:0]           wr_idx;
  logic [KIND_W-1:0]       tag_val;
  logic [COUNT_W-1:0]      cnt_val;
  logic [RES_HANDLE_W-1:0] res_handle;
  logic [STATUS_W-1:0]     res_status;
  logic [COUNT_W-1:0]      res_count;

  logic advance;
  logic q_full;
  logic q_empty;

  // The held request moves on whenever the result register is empty or is
  // being emptied in this cycle. The input register refills in the same
  // cycle, so a new item is taken every cycle while the result side flows.
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  assign q_full  = (fill_r == FW'(QUEUE_DEPTH));
  assign q_empty = (fill_r == '0);

  rsp_decide #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_decide (
    .func        (s1_func_r),
    .slot_handle (s1_handle_r),
    .slot_kind   (s1_kind_r),
    .tags        (tag_r),
    .counts      (cnt_r),
    .q_head      (queue_r[rd_pos_r]),
    .q_full      (q_full),
    .q_empty     (q_empty),
    .upd         (upd),
    .wr_idx      (wr_idx),
    .tag_val     (tag_val),
    .cnt_val     (cnt_val),
    .res_handle  (res_handle),
    .res_status  (res_status),
    .res_count   (res_count)
  );

  // Queue pointers wrap at the configured depth; a depth that is not a power
  // of two is handled by the explicit compare.
  always_comb begin
    rd_pos_nxt = rd_pos_r;
    wr_pos_nxt = wr_pos_r;
    fill_nxt   = fill_r;
    if (advance && upd.push) begin
      wr_pos_nxt = (wr_pos_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
      fill_nxt   = fill_r + 1'b1;
    end
    if (advance && upd.pop) begin
      rd_pos_nxt = (rd_pos_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_pos_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pos_r    <= '0;
      wr_pos_r    <= '0;
      fill_r      <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      rd_pos_r <= rd_pos_nxt;
      wr_pos_r <= wr_pos_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Slot tags and counts have a defined reset value, so they are cleared
  // directly; there are few enough slots to keep them in flip-flops.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (advance) begin
      if (upd.tag_we) begin
        tag_r[wr_idx] <= tag_val;
      end
      if (upd.cnt_we) begin
        cnt_r[wr_idx] <= cnt_val;
      end
    end
  end

  // Queue entries are only read once written, so they carry no reset.
  always_ff @(posedge clk) begin
    if (advance && upd.push) begin
      queue_r[wr_pos_r] <= wr_idx;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_func_r   <= in_chan.func;
      s1_handle_r <= in_chan.slot_handle;
      s1_kind_r   <= in_chan.slot_kind;
    end
    if (advance) begin
      out_handle_r <= res_handle;
      out_status_r <= res_status;
      out_count_r  <= res_count;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_handle = out_handle_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.count_after   = out_count_r;

endmodule

FILE: rtl/core/rsp_decide.sv
// ---------------------------------------------------------------------------
// rsp_decide: request decoder of the slot pool
// Checks one request against the current pool and queue state and produces
// the result fields together with the state updates to apply.
// ---------------------------------------------------------------------------
module rsp_decide import rsp_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic [FUNC_W-1:0]       func,
  input  logic [HANDLE_W-1:0]     slot_handle,
  input  logic [KIND_W-1:0]       slot_kind,
  input  logic [KIND_W-1:0]       tags     [SLOTS],
  input  logic [COUNT_W-1:0]      counts   [SLOTS],
  input  logic [SW-1:0]           q_head,
  input  logic                    q_full,
  input  logic                    q_empty,
  output upd_t                    upd,
  output logic [SW-1:0]           wr_idx,
  output logic [KIND_W-1:0]       tag_val,
  output logic [COUNT_W-1:0]      cnt_val,
  output logic [RES_HANDLE_W-1:0] res_handle,
  output logic [STATUS_W-1:0]     res_status,
  output logic [COUNT_W-1:0]      res_count
);

  logic [SLOTS-1:0]   free_vec;
  logic [SLOTS-1:0]   low_oh;
  logic [SW-1:0]      free_idx;
  logic               h_ok;
  logic [SW-1:0]      h_idx;
  logic [SW-1:0]      sel_idx;
  logic [KIND_W-1:0]  sel_tag;
  logic [COUNT_W-1:0] sel_cnt;
  logic               sel_max;

  // Lowest free slot: isolate the lowest set bit, then encode the one-hot.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = (tags[i] == '0);
    end
    low_oh   = free_vec & (~free_vec + 1'b1);
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (low_oh[i]) begin
        free_idx = free_idx | SW'(i);
      end
    end
  end

  assign h_ok    = ({3'b000, slot_handle} < 7'(SLOTS));
  assign h_idx   = SW'({3'b000, slot_handle});
  assign sel_idx = (func == FN_RECV) ? q_head : h_idx;
  assign sel_tag = tags[sel_idx];
  assign sel_cnt = counts[sel_idx];
  assign sel_max = (sel_cnt == COUNT_MAX);

  always_comb begin
    upd        = '0;
    wr_idx     = h_idx;
    tag_val    = '0;
    cnt_val    = sel_cnt + 1'b1;
    res_handle = '0;
    res_status = ST_OK;
    res_count  = '0;
    case (func)
      FN_ALLOC: begin
        if (slot_kind == '0) begin
          res_status = ST_BAD;
        end else if (free_vec == '0) begin
          res_status = ST_EXHAUSTED;
        end else begin
          upd.tag_we = 1'b1;
          upd.cnt_we = 1'b1;
          wr_idx     = free_idx;
          tag_val    = slot_kind;
          cnt_val    = COUNT_W'(1);
          res_handle = RES_HANDLE_W'(free_idx);
          res_count  = COUNT_W'(1);
        end
      end
      FN_RETAIN: begin
        if (!h_ok) begin
          res_status = ST_BAD;
        end else if (sel_tag == '0) begin
          res_status = ST_FREE;
        end else if (sel_max) begin
          res_status = ST_OVERFLOW;
        end else begin
          upd.cnt_we = 1'b1;
          res_count  = cnt_val;
        end
      end
      FN_RELEASE: begin
        cnt_val = sel_cnt - 1'b1;
        if (!h_ok) begin
          res_status = ST_BAD;
        end else if (sel_tag == '0 || sel_cnt == '0) begin
          res_status = ST_FREE;
        end else begin
          upd.cnt_we = 1'b1;
          // The last reference frees the slot.
          upd.tag_we = (cnt_val == '0);
          res_count  = cnt_val;
        end
      end
      FN_SEND: begin
        if (!h_ok) begin
          res_status = ST_BAD;
        end else if (q_full) begin
          res_status = ST_QUEUE;
        end else if (sel_tag == '0) begin
          res_status = ST_FREE;
        end else if (sel_max) begin
          res_status = ST_OVERFLOW;
        end else begin
          upd.cnt_we = 1'b1;
          upd.push   = 1'b1;
          res_count  = cnt_val;
        end
      end
      FN_RECV: begin
        if (q_empty) begin
          res_status = ST_QUEUE;
        end else begin
          upd.pop    = 1'b1;
          res_handle = RES_HANDLE_W'(q_head);
          res_count  = sel_cnt;
        end
      end
      default: begin
        res_status = ST_BAD;
      end
    endcase
  end

endmodule

FILE: rtl/core/rsp_checker.sv
// ---------------------------------------------------------------------------
// rsp_checker: port-level checks for the slot pool
// Watches the result channel and reset behaviour of the top level.
// ---------------------------------------------------------------------------
module rsp_checker import rsp_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [RES_HANDLE_W-1:0] out_result_handle,
  input logic [STATUS_W-1:0]     out_status,
  input logic [COUNT_W-1:0]      out_count_after
);

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its fields.
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_handle) && $stable(out_status)
      && $stable(out_count_after))
    else $error("result fields changed while stalled");

  // Refused or faulting requests report zero handle and count.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_handle == '0
      && out_count_after == '0)
    else $error("nonzero fields on a refused item");

  // Only defined status codes appear.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_EXHAUSTED)
    else $error("undefined status code");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind refcounted_slot_pool_with_fifo rsp_checker u_rsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_result_handle (out_chan.result_handle),
  .out_status        (out_chan.status),
  .out_count_after   (out_chan.count_after)
);

FILE: dv/slot_pool_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// slot_pool_checker: result prediction and comparison for the slot pool
// Watches the request and result channels. It models the slot tags, the
// reference counts and the handle queue for every accepted request, and
// compares each accepted result with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module slot_pool_checker import rsp_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rsp_in_if           req_mon,
  rsp_out_if          res_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [RES_HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
  } pool_result_t;

  logic [KIND_W-1:0]  slot_tags [SLOTS];
  logic [COUNT_W-1:0] slot_refs [SLOTS];
  int unsigned        queued_slots [$];
  pool_result_t       awaited_results [$];

  // Applies one request to the model and returns the result it should give.
  // Refused requests leave the model untouched and report zero fields.
  function automatic pool_result_t apply_request(input logic [FUNC_W-1:0]   fn,
                                                 input logic [HANDLE_W-1:0] h,
                                                 input logic [KIND_W-1:0]   kind);
    pool_result_t r;
    int           free_slot;
    int unsigned  s;
    r         = '0;
    free_slot = -1;
    s         = h;
    case (fn)
      FN_ALLOC: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_tags[i] == '0) free_slot = i;
        end
        if (kind == '0) begin
          r.status = ST_BAD;
        end else if (free_slot < 0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          slot_tags[free_slot] = kind;
          slot_refs[free_slot] = COUNT_W'(1);
          r.handle             = RES_HANDLE_W'(free_slot);
          r.count              = COUNT_W'(1);
        end
      end
      FN_RETAIN: begin
        if (s >= SLOTS) begin
          r.status = ST_BAD;
        end else if (slot_tags[s] == '0) begin
          r.status = ST_FREE;
        end else if (slot_refs[s] == COUNT_MAX) begin
          r.status = ST_OVERFLOW;
        end else begin
          slot_refs[s] = slot_refs[s] + 1'b1;
          r.count      = slot_refs[s];
        end
      end
      FN_RELEASE: begin
        if (s >= SLOTS) begin
          r.status = ST_BAD;
        end else if (slot_tags[s] == '0 || slot_refs[s] == '0) begin
          r.status = ST_FREE;
        end else begin
          slot_refs[s] = slot_refs[s] - 1'b1;
          if (slot_refs[s] == '0) slot_tags[s] = '0;
          r.count = slot_refs[s];
        end
      end
      FN_SEND: begin
        // Bad handle first, then a full queue, then the retain checks.
        if (s >= SLOTS) begin
          r.status = ST_BAD;
        end else if (queued_slots.size() >= QUEUE_DEPTH) begin
          r.status = ST_QUEUE;
        end else if (slot_tags[s] == '0) begin
          r.status = ST_FREE;
        end else if (slot_refs[s] == COUNT_MAX) begin
          r.status = ST_OVERFLOW;
        end else begin
          queued_slots.push_back(s);
          slot_refs[s] = slot_refs[s] + 1'b1;
          r.count      = slot_refs[s];
        end
      end
      FN_RECV: begin
        if (queued_slots.size() == 0) begin
          r.status = ST_QUEUE;
        end else begin
          // The count may have dropped to zero since the handle was queued.
          s        = queued_slots.pop_front();
          r.handle = RES_HANDLE_W'(s);
          r.count  = slot_refs[s];
        end
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned field_differs(input string              name,
                                                input logic [COUNT_W-1:0] want,
                                                input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : compare
    pool_result_t due;
    int unsigned  fails;
    fails = 0;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_tags[i] = '0;
        slot_refs[i] = '0;
      end
      queued_slots.delete();
      awaited_results.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // A result leaving now belongs to an earlier request, so it is matched
      // before the request accepted on the same edge is predicted.
      if (res_mon.valid && res_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: unexpected result: expected none, actual handle %0d status %0d count %0d",
                   $time, res_mon.result_handle, res_mon.status, res_mon.count_after);
          fails = 1;
        end else begin
          due   = awaited_results.pop_front();
          fails = field_differs("result_handle", due.handle, res_mon.result_handle)
                + field_differs("status", due.status, res_mon.status)
                + field_differs("count_after", due.count, res_mon.count_after);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        awaited_results.push_back(apply_request(req_mon.func, req_mon.slot_handle,
                                                req_mon.slot_kind));
      end
      fail_count <= fail_count + fails;
      pending    <= awaited_results.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the reference-counted slot pool
// Drives directed and random requests into the pool, paces the result side
// with random stalls and one long hold-off, and leaves prediction and
// comparison to the checker that sits beside the block.
// ---------------------------------------------------------------------------
module tb_top;
  import rsp_pkg::*;

  localparam int SLOTS          = SLOTS_DEF;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int PHASE_LEN      = 250;   // random items per traffic mix
  localparam int IDLE_PCT       = 17;    // chance of a gap or stall per item
  localparam int HOLD_CYCLES    = 200;   // long hold-off on the result side
  localparam int DRAIN_CYCLES   = 8;     // idle wait after the last predicted result
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any item moving

  logic        clk;
  logic        rst_n;
  logic        calm;      // suppresses gaps and stalls on both sides
  logic        squeeze;   // asks the result side for its long hold-off
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;

  rsp_in_if  req_chan ();
  rsp_out_if res_chan ();

  refcounted_slot_pool_with_fifo DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  slot_pool_checker pool_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_chan),
    .res_mon    (res_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one request and returns on the edge at which it is accepted.
  // Before the request the sender may pause; valid is lowered once for the
  // whole pause so that it never drops and rises in the same step.
  task automatic offer_request(input logic [FUNC_W-1:0]   fn,
                               input logic [HANDLE_W-1:0] h,
                               input logic [KIND_W-1:0]   kind);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_chan.valid       <= 1'b1;
    req_chan.func        <= fn;
    req_chan.slot_handle <= h;
    req_chan.slot_kind   <= kind;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
  endtask

  initial begin : stimulus
    int                  roll;
    int                  cut [5];
    logic [FUNC_W-1:0]   fn;
    logic [HANDLE_W-1:0] h;
    logic [KIND_W-1:0]   kind;

    rst_n                <= 1'b0;
    calm                 <= 1'b0;
    squeeze              <= 1'b0;
    req_chan.valid       <= 1'b0;
    req_chan.func        <= FN_ALLOC;
    req_chan.slot_handle <= '0;
    req_chan.slot_kind   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. From an empty pool: refusals on free slots and an
    // empty queue, bad handles and unknown requests, then every slot taken
    // so that a further alloc finds the pool exhausted.
    offer_request(FN_RECV, '0, '0);
    offer_request(FN_RELEASE, '0, '0);
    offer_request(FN_RETAIN, HANDLE_W'(3), '0);
    offer_request(FN_SEND, HANDLE_W'(2), '0);
    offer_request(FN_SEND, HANDLE_W'((1 << HANDLE_W) - 1), '0);
    offer_request(FN_RETAIN, HANDLE_W'(SLOTS), '0);
    offer_request(FN_RECV + FUNC_W'(1), '0, KIND_W'(1));
    offer_request(FN_RECV + FUNC_W'(3), '0, KIND_W'(3));
    offer_request(FN_ALLOC, '0, '0);
    for (int i = 0; i < SLOTS; i++) begin
      offer_request(FN_ALLOC, '0, KIND_W'(1 + i % 3));
    end
    offer_request(FN_ALLOC, '0, KIND_W'(3));

    // Fill the queue, then show that a full queue refuses a good handle but
    // a bad handle is reported as such even then.
    offer_request(FN_RETAIN, HANDLE_W'(7), '0);
    offer_request(FN_SEND, HANDLE_W'(7), '0);
    offer_request(FN_SEND, HANDLE_W'(0), '0);
    offer_request(FN_SEND, HANDLE_W'(3), '0);
    offer_request(FN_SEND, HANDLE_W'(5), '0);
    offer_request(FN_SEND, HANDLE_W'(1), '0);
    offer_request(FN_SEND, HANDLE_W'((1 << HANDLE_W) - 1), '0);

    // Slot 0 is freed while its handle is still queued; receiving it then
    // reports a count of zero.
    offer_request(FN_RELEASE, HANDLE_W'(0), '0);
    offer_request(FN_RELEASE, HANDLE_W'(0), '0);
    offer_request(FN_RECV, '0, '0);
    offer_request(FN_RECV, '0, '0);

    // Random part in phases of different traffic mixes: balanced, alloc
    // heavy to reach exhaustion, queue heavy to hit full and empty, and
    // release heavy to drain the pool. The third phase runs with no gaps or
    // stalls at all, and the long result hold-off falls in the second.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 2 * PHASE_LEN && n < 3 * PHASE_LEN);
      if (n == PHASE_LEN + PHASE_LEN / 5) squeeze <= 1'b1;
      case ((n / PHASE_LEN) % 4)
        0:       cut = '{22, 37, 62, 77, 95};
        1:       cut = '{40, 60, 75, 85, 95};
        2:       cut = '{15, 20, 35, 65, 97};
        default: cut = '{15, 25, 70, 80, 95};
      endcase
      roll = $urandom_range(99);
      if (roll < cut[0])      fn = FN_ALLOC;
      else if (roll < cut[1]) fn = FN_RETAIN;
      else if (roll < cut[2]) fn = FN_RELEASE;
      else if (roll < cut[3]) fn = FN_SEND;
      else if (roll < cut[4]) fn = FN_RECV;
      else                    fn = FN_RECV + FUNC_W'($urandom_range(1, 3));

      // Alloc hands out the lowest free slots, so the low half is favoured
      // to hit live slots more often; a tenth of handles are out of range.
      if ($urandom_range(9) == 0) begin
        h = HANDLE_W'($urandom_range(SLOTS, (1 << HANDLE_W) - 1));
      end else if ($urandom_range(1) == 1) begin
        h = HANDLE_W'($urandom_range(SLOTS / 2 - 1));
      end else begin
        h = HANDLE_W'($urandom_range(SLOTS - 1));
      end
      kind = ($urandom_range(7) == 0) ? '0 : KIND_W'($urandom_range(1, 3));
      offer_request(fn, h, kind);
    end

    // Let every predicted result arrive, then wait DRAIN_CYCLES more in case
    // the block sends something it should not.
    req_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side pacing. Random stalls outside calm stretches, and once a
  // long hold-off while the sender keeps offering, so that the block fills
  // up and has to stall its request side.
  initial begin : result_pacing
    bit held;
    held = 1'b0;
    res_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze && !held) begin
        held = 1'b1;
        res_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // Watchdog: any item moving on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (req_chan.valid && req_chan.ready) ||
        (res_chan.valid && res_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
rtl/core/rsp_pkg.sv
rtl/core/rsp_chan_if.sv
rtl/core/rsp_decide.sv
rtl/core/refcounted_slot_pool_with_fifo.sv
rtl/core/rsp_checker.sv
dv/slot_pool_checker.sv
dv/tb_top.sv
